// ===== design/bact_pkg.sv =====
`default_nettype none

package bact_pkg;

  localparam int TABLE_DEPTH_DEF      = 16;
  localparam int MAX_REPORT_BYTES_DEF = 62;

  localparam int ADDR_W  = 48;
  localparam int ATYPE_W = 2;
  localparam int RSSI_W  = 8;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 5;

  // manufacturer element type and the tracker prefix
  localparam logic [BYTE_W-1:0] MFR_TYPE = 8'hFF;
  localparam logic [BYTE_W-1:0] PFX_0    = 8'h4C;
  localparam logic [BYTE_W-1:0] PFX_1    = 8'h00;
  localparam logic [BYTE_W-1:0] PFX_2    = 8'h12;
  localparam logic [BYTE_W-1:0] MIN_MFR_LEN = 8'd4;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_BYTE   = 2'd1,
    REQ_COMMIT = 2'd2,
    REQ_PICK   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    KIND_IGNORED = 3'd0,
    KIND_UPDATED = 3'd1,
    KIND_ADDED   = 3'd2,
    KIND_FULL    = 3'd3,
    KIND_PICK    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_PICK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0]         address;
    logic [ATYPE_W-1:0]        atype;
    logic signed [RSSI_W-1:0]  strength;
    logic                      findmy;
  } entry_t;

  typedef struct packed {
    logic  take_byte;
    logic  clear;
    logic  start;
    logic  scan_merge;
    logic  scan_pick;
    logic  update;
    logic  append;
    logic  load_out;
    kind_e kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_done;
    logic full;
    logic merge_req;
    logic out_free;
  } ctrl_st_t;

endpackage

`default_nettype wire

// ===== design/bact_if.sv =====
`default_nettype none

interface bact_req_if import bact_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [BYTE_W-1:0]         payload_byte;
  logic [ADDR_W-1:0]         device_address;
  logic [ATYPE_W-1:0]        address_type;
  logic signed [RSSI_W-1:0]  signal_strength;
  logic                      connectable;

  modport source (
    output valid, req_type, payload_byte, device_address, address_type,
           signal_strength, connectable,
    input  ready
  );
  modport sink (
    input  valid, req_type, payload_byte, device_address, address_type,
           signal_strength, connectable,
    output ready
  );
endinterface

interface bact_rsp_if import bact_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [2:0]                result_kind;
  logic                      report_findmy;
  logic                      best_found;
  logic [ADDR_W-1:0]         best_address;
  logic [ATYPE_W-1:0]        best_address_type;
  logic signed [RSSI_W-1:0]  best_strength;
  logic                      best_is_findmy;
  logic [COUNT_W-1:0]        entry_count;

  modport source (
    output valid, result_kind, report_findmy, best_found, best_address,
           best_address_type, best_strength, best_is_findmy, entry_count,
    input  ready
  );
  modport sink (
    input  valid, result_kind, report_findmy, best_found, best_address,
           best_address_type, best_strength, best_is_findmy, entry_count,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/bact_parser.sv =====
`default_nettype none

module bact_parser import bact_pkg::*; #(
  parameter int MAX_REPORT_BYTES = MAX_REPORT_BYTES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              take_i,
  input  wire logic              restart_i,
  input  wire logic [BYTE_W-1:0] byte_i,
  output logic                   seen_findmy_o
);

  localparam int PW = $clog2(MAX_REPORT_BYTES + 1);

  localparam logic [BYTE_W-1:0] OFF_KIND = 8'd1;
  localparam logic [BYTE_W-1:0] OFF_P0   = 8'd2;
  localparam logic [BYTE_W-1:0] OFF_P1   = 8'd3;
  localparam logic [BYTE_W-1:0] OFF_P2   = 8'd4;

  logic [PW-1:0]     pos_q, pos_d;
  logic [BYTE_W-1:0] len_q, len_d;
  logic [BYTE_W-1:0] off_q, off_d;
  logic [BYTE_W-1:0] kind_q, kind_d;
  logic              pm_q, pm_d;
  logic              halted_q, halted_d;
  logic              seen_q, seen_d;

  logic [BYTE_W-1:0] off_n;
  logic [BYTE_W-1:0] kind_n;
  logic              pm_n;

  assign off_n  = off_q + 8'd1;
  assign kind_n = (off_n == OFF_KIND) ? byte_i : kind_q;

  always_comb begin
    pm_n = pm_q;
    if (off_n == OFF_P0 && byte_i != PFX_0) pm_n = 1'b0;
    if (off_n == OFF_P1 && byte_i != PFX_1) pm_n = 1'b0;
    if (off_n == OFF_P2 && byte_i != PFX_2) pm_n = 1'b0;
  end

  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    off_d    = off_q;
    kind_d   = kind_q;
    pm_d     = pm_q;
    halted_d = halted_q;
    seen_d   = seen_q;
    if (restart_i) begin
      pos_d    = '0;
      len_d    = '0;
      off_d    = '0;
      kind_d   = '0;
      pm_d     = 1'b0;
      halted_d = 1'b0;
      seen_d   = 1'b0;
    end else if (take_i && pos_q < PW'(MAX_REPORT_BYTES)) begin
      pos_d = pos_q + PW'(1);
      if (!halted_q) begin
        if (len_q == '0) begin
          // length byte; zero stops the walk
          if (byte_i == '0) begin
            halted_d = 1'b1;
          end else begin
            len_d  = byte_i;
            off_d  = '0;
            kind_d = '0;
            pm_d   = 1'b1;
          end
        end else begin
          kind_d = kind_n;
          pm_d   = pm_n;
          if (off_n == len_q) begin
            if (kind_n == MFR_TYPE && len_q >= MIN_MFR_LEN && pm_n) begin
              seen_d = 1'b1;
            end
            len_d = '0;
            off_d = '0;
          end else begin
            off_d = off_n;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      len_q    <= '0;
      off_q    <= '0;
      kind_q   <= '0;
      pm_q     <= 1'b0;
      halted_q <= 1'b0;
      seen_q   <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      len_q    <= len_d;
      off_q    <= off_d;
      kind_q   <= kind_d;
      pm_q     <= pm_d;
      halted_q <= halted_d;
      seen_q   <= seen_d;
    end
  end

  assign seen_findmy_o = seen_q;

endmodule

`default_nettype wire

// ===== design/bact_datapath.sv =====
`default_nettype none

module bact_datapath import bact_pkg::*; #(
  parameter int TABLE_DEPTH      = TABLE_DEPTH_DEF,
  parameter int MAX_REPORT_BYTES = MAX_REPORT_BYTES_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire ctrl_cmd_t                 cmd_i,
  output ctrl_st_t                       st_o,
  input  wire logic [1:0]                req_type_i,
  input  wire logic [BYTE_W-1:0]         payload_byte_i,
  input  wire logic [ADDR_W-1:0]         device_address_i,
  input  wire logic [ATYPE_W-1:0]        address_type_i,
  input  wire logic signed [RSSI_W-1:0]  signal_strength_i,
  input  wire logic                      connectable_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [2:0]                     result_kind_o,
  output logic                           report_findmy_o,
  output logic                           best_found_o,
  output logic [ADDR_W-1:0]              best_address_o,
  output logic [ATYPE_W-1:0]             best_address_type_o,
  output logic signed [RSSI_W-1:0]       best_strength_o,
  output logic                           best_is_findmy_o,
  output logic [COUNT_W-1:0]             entry_count_o
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic seen_findmy;

  bact_parser #(
    .MAX_REPORT_BYTES(MAX_REPORT_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (cmd_i.take_byte),
    .restart_i    (cmd_i.start && req_e'(req_type_i) == REQ_COMMIT),
    .byte_i       (payload_byte_i),
    .seen_findmy_o(seen_findmy)
  );

  // table storage, one write and one registered read per cycle
  entry_t mem [TABLE_DEPTH];

  logic [CW-1:0] filled_q, filled_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [AW-1:0] rd_idx_q;
  logic          rd_vld_q;
  entry_t        rd_q;

  entry_t        key_q;
  entry_t        best_q;
  logic          best_vld_q;

  logic          issue;
  logic          hit;
  logic          better;
  logic          full;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;

  logic          out_valid_q;
  logic [2:0]    out_kind_q;
  logic          out_fm_q;
  logic          out_found_q;
  entry_t        out_best_q;
  logic [COUNT_W-1:0] out_count_q;
  logic          out_free;

  assign full     = (filled_q == CW'(TABLE_DEPTH));
  assign hit      = cmd_i.scan_merge && rd_vld_q && (rd_q.address == key_q.address);
  assign issue    = (cmd_i.scan_merge || cmd_i.scan_pick) && (idx_q < filled_q) && !hit;
  assign out_free = !out_valid_q || out_ready_i;

  // tracker entries first, then strictly stronger
  always_comb begin
    if (!best_vld_q) begin
      better = 1'b1;
    end else if (rd_q.findmy != best_q.findmy) begin
      better = rd_q.findmy;
    end else begin
      better = rd_q.strength > best_q.strength;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = rd_idx_q;
    wdata = rd_q;
    if (cmd_i.update) begin
      we = 1'b1;
      if (key_q.strength > rd_q.strength) wdata.strength = key_q.strength;
      wdata.findmy = rd_q.findmy || key_q.findmy;
    end else if (cmd_i.append) begin
      we    = 1'b1;
      waddr = filled_q[AW-1:0];
      wdata = key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (issue) rd_q <= mem[idx_q[AW-1:0]];
  end

  always_comb begin
    filled_d = filled_q;
    if (cmd_i.clear) begin
      filled_d = '0;
    end else if (cmd_i.append) begin
      filled_d = filled_q + CW'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.start) begin
      idx_d = '0;
    end else if (issue) begin
      idx_d = idx_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q   <= '0;
      idx_q      <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
    end else begin
      filled_q <= filled_d;
      idx_q    <= idx_d;
      rd_vld_q <= issue;
      if (cmd_i.start) begin
        best_vld_q <= 1'b0;
      end else if (cmd_i.scan_pick && rd_vld_q) begin
        best_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) rd_idx_q <= idx_q[AW-1:0];
    if (cmd_i.start) begin
      key_q.address  <= device_address_i;
      key_q.atype    <= address_type_i;
      key_q.strength <= signal_strength_i;
      key_q.findmy   <= (req_e'(req_type_i) == REQ_COMMIT) && seen_findmy;
    end else if (cmd_i.clear) begin
      key_q.findmy <= 1'b0;
    end
    if (cmd_i.scan_pick && rd_vld_q && better) best_q <= rd_q;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_kind_q  <= cmd_i.kind;
      out_fm_q    <= key_q.findmy;
      out_found_q <= (cmd_i.kind == KIND_PICK) && best_vld_q;
      out_best_q  <= ((cmd_i.kind == KIND_PICK) && best_vld_q) ? best_q : '0;
      out_count_q <= COUNT_W'(filled_q);
    end
  end

  assign st_o.hit       = hit;
  assign st_o.scan_done = !(idx_q < filled_q) && !rd_vld_q;
  assign st_o.full      = full;
  assign st_o.merge_req = seen_findmy || connectable_i;
  assign st_o.out_free  = out_free;

  assign out_valid_o         = out_valid_q;
  assign result_kind_o       = out_kind_q;
  assign report_findmy_o     = out_fm_q;
  assign best_found_o        = out_found_q;
  assign best_address_o      = out_best_q.address;
  assign best_address_type_o = out_best_q.atype;
  assign best_strength_o     = out_best_q.strength;
  assign best_is_findmy_o    = out_best_q.findmy;
  assign entry_count_o       = out_count_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> !full)
    else $error("append into a full table");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> filled_q == '0)
    else $error("table not empty after clear");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> out_free)
    else $error("result overwritten before it was taken");

  a_no_dual_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.update && cmd_i.append))
    else $error("update and append in one cycle");
`endif

endmodule

`default_nettype wire

// ===== design/bact_ctrl.sv =====
`default_nettype none

module bact_ctrl import bact_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] req_type_i,
  input  wire ctrl_st_t   st_i,
  output ctrl_cmd_t       cmd_o
);

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;
  logic   accept;
  req_e   req;

  assign req    = req_e'(req_type_i);
  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req)
            REQ_BYTE: state_d = ST_IDLE;
            REQ_CLEAR: begin
              kind_d  = KIND_IGNORED;
              state_d = ST_FINISH;
            end
            REQ_COMMIT: begin
              kind_d  = KIND_IGNORED;
              state_d = st_i.merge_req ? ST_MERGE : ST_FINISH;
            end
            REQ_PICK: begin
              kind_d  = KIND_PICK;
              state_d = ST_PICK;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_MERGE: begin
        priority if (st_i.hit) begin
          kind_d  = KIND_UPDATED;
          state_d = ST_FINISH;
        end else if (st_i.scan_done) begin
          kind_d  = st_i.full ? KIND_FULL : KIND_ADDED;
          state_d = ST_FINISH;
        end
      end
      ST_PICK: begin
        if (st_i.scan_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (st_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.kind = kind_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.take_byte = accept && (req == REQ_BYTE);
        cmd_o.clear     = accept && (req == REQ_CLEAR);
        cmd_o.start     = accept && (req == REQ_COMMIT || req == REQ_PICK);
      end
      ST_MERGE: begin
        cmd_o.scan_merge = 1'b1;
        cmd_o.update     = st_i.hit;
        cmd_o.append     = !st_i.hit && st_i.scan_done && !st_i.full;
      end
      ST_PICK: begin
        cmd_o.scan_pick = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.load_out = st_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_IGNORED;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

`default_nettype wire

// ===== design/ble_adv_tracker_candidate_table.sv =====
// Candidate table for a BLE advertising scan filter.
// req_i carries one item per handshake: a report payload byte, an end of
// report with the advertiser address, type, signal strength and the
// connectable flag, a clear request or a pick request. rsp_o carries one
// result for every item except a payload byte.
// A payload byte leaves the block idle, so the next item may follow in the
// next cycle. An end of report that merges, or a pick, walks the filled
// table entries through the single read port of the table memory, one
// entry a cycle. Clear and a report that is not merged go straight to
// the final state.
// The result sits in an output register; byte items keep flowing while it
// waits, and an item that produces a result holds in its final state until
// the output register is free, so a stalled receiver stops requests only
// at the next result.
// Reset empties the table and restarts the payload walk; table entries are
// never read above the fill count, so the table memory itself is not
// cleared.
`default_nettype none

module ble_adv_tracker_candidate_table import bact_pkg::*; #(
  parameter int TABLE_DEPTH      = TABLE_DEPTH_DEF,
  parameter int MAX_REPORT_BYTES = MAX_REPORT_BYTES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bact_req_if.sink  req_i,
  bact_rsp_if.source rsp_o
);

  ctrl_cmd_t cmd;
  ctrl_st_t  st;

  bact_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(req_i.valid),
    .in_ready_o(req_i.ready),
    .req_type_i(req_i.req_type),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  bact_datapath #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .MAX_REPORT_BYTES(MAX_REPORT_BYTES)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .st_o               (st),
    .req_type_i         (req_i.req_type),
    .payload_byte_i     (req_i.payload_byte),
    .device_address_i   (req_i.device_address),
    .address_type_i     (req_i.address_type),
    .signal_strength_i  (req_i.signal_strength),
    .connectable_i      (req_i.connectable),
    .out_valid_o        (rsp_o.valid),
    .out_ready_i        (rsp_o.ready),
    .result_kind_o      (rsp_o.result_kind),
    .report_findmy_o    (rsp_o.report_findmy),
    .best_found_o       (rsp_o.best_found),
    .best_address_o     (rsp_o.best_address),
    .best_address_type_o(rsp_o.best_address_type),
    .best_strength_o    (rsp_o.best_strength),
    .best_is_findmy_o   (rsp_o.best_is_findmy),
    .entry_count_o      (rsp_o.entry_count)
  );

endmodule

`default_nettype wire

// ===== tb/ble_adv_tracker_candidate_table_tb.sv =====
`default_nettype none

module ble_adv_tracker_candidate_table_tb import bact_pkg::*; ();

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 1150;
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL_SIZE = 24;

  typedef struct {
    req_e                req;
    logic [BYTE_W-1:0]   data;
    logic [ADDR_W-1:0]   addr;
    logic [ATYPE_W-1:0]  atype;
    logic signed [RSSI_W-1:0] rssi;
    logic                conn;
  } req_item_t;

  typedef struct packed {
    kind_e                    kind;
    logic                     fm;
    logic                     found;
    logic [ADDR_W-1:0]        addr;
    logic [ATYPE_W-1:0]       atype;
    logic signed [RSSI_W-1:0] rssi;
    logic                     best_fm;
    logic [COUNT_W-1:0]       count;
  } scan_answer_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bact_req_if req_if ();
  bact_rsp_if rsp_if ();

  ble_adv_tracker_candidate_table DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // table and payload walk mirror
  logic [ADDR_W-1:0]        tbl_addr  [TABLE_DEPTH_DEF];
  logic [ATYPE_W-1:0]       tbl_atype [TABLE_DEPTH_DEF];
  logic signed [RSSI_W-1:0] tbl_rssi  [TABLE_DEPTH_DEF];
  logic                     tbl_fm    [TABLE_DEPTH_DEF];
  int unsigned              tbl_fill = 0;
  int unsigned              rpt_pos = 0;
  logic [BYTE_W-1:0]        el_len = '0;
  logic [BYTE_W-1:0]        el_off = '0;
  logic [BYTE_W-1:0]        el_type = '0;
  logic                     pfx_ok = 1'b0;
  logic                     walk_stop = 1'b0;
  logic                     rpt_tracker = 1'b0;

  req_item_t         req_backlog [$];
  scan_answer_t      answers_due [$];
  logic [BYTE_W-1:0] rpt_bytes [$];
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  int          n_errors = 0;
  int unsigned n_accepted = 0;
  logic [31:0] cycle_cnt = '0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  req_item_t   drv_cur;

  function automatic void restart_walk();
    rpt_pos = 0;
    el_len = '0;
    el_off = '0;
    el_type = '0;
    pfx_ok = 1'b0;
    walk_stop = 1'b0;
    rpt_tracker = 1'b0;
  endfunction

  function automatic void walk_byte(input logic [BYTE_W-1:0] b);
    if (rpt_pos >= MAX_REPORT_BYTES_DEF) return;
    rpt_pos++;
    if (walk_stop) return;
    if (el_len == '0) begin
      // zero length byte halts the walk for the rest of the report
      if (b == 8'h00) begin
        walk_stop = 1'b1;
      end else begin
        el_len = b;
        el_off = '0;
        el_type = '0;
        pfx_ok = 1'b1;
      end
      return;
    end
    el_off++;
    case (el_off)
      8'd1: el_type = b;
      8'd2: if (b != PFX_0) pfx_ok = 1'b0;
      8'd3: if (b != PFX_1) pfx_ok = 1'b0;
      8'd4: if (b != PFX_2) pfx_ok = 1'b0;
      default: ;
    endcase
    if (el_off == el_len) begin
      if (el_type == MFR_TYPE && el_len >= MIN_MFR_LEN && pfx_ok) rpt_tracker = 1'b1;
      el_len = '0;
      el_off = '0;
    end
  endfunction

  // returns 1 when the item produces an answer
  function automatic bit compute_answer(input req_item_t it, output scan_answer_t a);
    int best;
    bit hit;
    a = '0;
    case (it.req)
      REQ_BYTE: begin
        walk_byte(it.data);
        return 1'b0;
      end
      REQ_CLEAR: begin
        tbl_fill = 0;
        a.kind = KIND_IGNORED;
      end
      REQ_COMMIT: begin
        a.kind = KIND_IGNORED;
        a.fm = rpt_tracker;
        if (rpt_tracker || it.conn) begin
          hit = 1'b0;
          for (int i = 0; i < tbl_fill; i++) begin
            if (!hit && tbl_addr[i] == it.addr) begin
              if (it.rssi > tbl_rssi[i]) tbl_rssi[i] = it.rssi;
              if (rpt_tracker) tbl_fm[i] = 1'b1;
              hit = 1'b1;
              a.kind = KIND_UPDATED;
            end
          end
          if (!hit) begin
            if (tbl_fill < TABLE_DEPTH_DEF) begin
              tbl_addr[tbl_fill] = it.addr;
              tbl_atype[tbl_fill] = it.atype;
              tbl_rssi[tbl_fill] = it.rssi;
              tbl_fm[tbl_fill] = rpt_tracker;
              tbl_fill++;
              a.kind = KIND_ADDED;
            end else begin
              a.kind = KIND_FULL;
            end
          end
        end
        restart_walk();
      end
      default: begin
        best = -1;
        for (int i = 0; i < tbl_fill; i++) begin
          if (best < 0) best = i;
          else if (tbl_fm[i] != tbl_fm[best]) begin
            if (tbl_fm[i]) best = i;
          end else if (tbl_rssi[i] > tbl_rssi[best]) begin
            best = i;
          end
        end
        a.kind = KIND_PICK;
        if (best >= 0) begin
          a.found = 1'b1;
          a.addr = tbl_addr[best];
          a.atype = tbl_atype[best];
          a.rssi = tbl_rssi[best];
          a.best_fm = tbl_fm[best];
        end
      end
    endcase
    a.count = COUNT_W'(tbl_fill);
    return 1'b1;
  endfunction

  // mostly short gaps, a few long ones, none at all in calm windows
  function automatic int gap_len(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic req_item_t noise_item(input req_e k);
    req_item_t it;
    it.req = k;
    it.data = BYTE_W'($urandom);
    it.addr = {16'($urandom), 32'($urandom)};
    it.atype = ATYPE_W'($urandom);
    it.rssi = RSSI_W'($urandom);
    it.conn = 1'($urandom);
    return it;
  endfunction

  task automatic add_byte(input logic [BYTE_W-1:0] b);
    req_item_t it;
    it = noise_item(REQ_BYTE);
    it.data = b;
    req_backlog.push_back(it);
  endtask

  task automatic add_commit(input logic [ADDR_W-1:0] addr, input logic [ATYPE_W-1:0] atype,
                            input logic signed [RSSI_W-1:0] rssi, input logic conn);
    req_item_t it;
    it = noise_item(REQ_COMMIT);
    it.addr = addr;
    it.atype = atype;
    it.rssi = rssi;
    it.conn = conn;
    req_backlog.push_back(it);
  endtask

  task automatic add_op(input req_e k);
    req_backlog.push_back(noise_item(k));
  endtask

  task automatic add_bytes(input logic [BYTE_W-1:0] b [$]);
    foreach (b[k]) add_byte(b[k]);
  endtask

  function automatic logic [BYTE_W-1:0] near_prefix(input int k);
    if ($urandom_range(0, 9) < 3) return BYTE_W'($urandom);
    case (k)
      1: return PFX_0;
      2: return PFX_1;
      3: return PFX_2;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  task automatic put_element(input bit tracker);
    int n;
    n = tracker ? $urandom_range(4, 9) : $urandom_range(1, 10);
    rpt_bytes.push_back(BYTE_W'(n));
    if (tracker) begin
      rpt_bytes.push_back(MFR_TYPE);
      rpt_bytes.push_back(PFX_0);
      rpt_bytes.push_back(PFX_1);
      rpt_bytes.push_back(PFX_2);
      repeat (n - 4) rpt_bytes.push_back(BYTE_W'($urandom));
    end else begin
      // often the manufacturer type with a near miss or a short body
      rpt_bytes.push_back(($urandom_range(0, 2) == 0) ? MFR_TYPE : BYTE_W'($urandom));
      for (int k = 1; k < n; k++) rpt_bytes.push_back(near_prefix(k));
    end
  endtask

  task automatic add_report();
    int shape;
    int target;
    logic [ADDR_W-1:0] addr;
    shape = $urandom_range(0, 99);
    rpt_bytes.delete();
    if (shape < 30) begin
      // bare end of report
    end else if (shape < 60) begin
      put_element(1'b1);
    end else if (shape < 85) begin
      repeat ($urandom_range(2, 4)) begin
        if ($urandom_range(0, 9) == 0) rpt_bytes.push_back(8'h00);
        put_element($urandom_range(0, 2) == 0);
      end
    end else if (shape < 93) begin
      repeat ($urandom_range(1, 20)) rpt_bytes.push_back(BYTE_W'($urandom));
    end else begin
      // long report, the tracker element lands near or past the byte cap
      target = $urandom_range(52, 66);
      while (rpt_bytes.size() < target) put_element(1'b0);
      put_element(1'b1);
    end
    // overrunning element: cut the tail
    if (rpt_bytes.size() > 1 && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        if (rpt_bytes.size() > 0) void'(rpt_bytes.pop_back());
      end
    end
    foreach (rpt_bytes[k]) begin
      if ($urandom_range(0, 59) == 0) add_op(REQ_CLEAR);
      add_byte(rpt_bytes[k]);
    end
    addr = ($urandom_range(0, 9) < 7) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                      : {16'($urandom), 32'($urandom)};
    add_commit(addr, ATYPE_W'($urandom), RSSI_W'($urandom), 1'($urandom));
  endtask

  // driver
  always @(posedge clk_i) begin
    bit fire;
    scan_answer_t a;
    if (rst_ni) begin
      fire = req_if.valid && req_if.ready;
      if (fire) begin
        if (compute_answer(drv_cur, a)) answers_due.push_back(a);
        n_accepted <= n_accepted + 1;
      end
      if (!req_if.valid || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          drv_cur = req_backlog.pop_front();
          req_if.req_type <= drv_cur.req;
          req_if.payload_byte <= drv_cur.data;
          req_if.device_address <= drv_cur.addr;
          req_if.address_type <= drv_cur.atype;
          req_if.signal_strength <= drv_cur.rssi;
          req_if.connectable <= drv_cur.conn;
          req_if.valid <= 1'b1;
          gap_left = gap_len(cycle_cnt[11:10] == 2'd0);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once the run is well under way
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && n_accepted >= 300) begin
        hold_left <= 400;
        hold_done <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    scan_answer_t got;
    scan_answer_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.kind = kind_e'(rsp_if.result_kind);
        got.fm = rsp_if.report_findmy;
        got.found = rsp_if.best_found;
        got.addr = rsp_if.best_address;
        got.atype = rsp_if.best_address_type;
        got.rssi = rsp_if.best_strength;
        got.best_fm = rsp_if.best_is_findmy;
        got.count = rsp_if.entry_count;
        if (answers_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result: kind %0d count %0d", got.kind, got.count);
        end else begin
          want = answers_due.pop_front();
          if (got.kind !== want.kind || got.fm !== want.fm || got.found !== want.found ||
              got.addr !== want.addr || got.atype !== want.atype ||
              got.rssi !== want.rssi || got.best_fm !== want.best_fm ||
              got.count !== want.count) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("mismatch exp: kind %0d fm %b found %b addr %h type %0d rssi %0d bfm %b cnt %0d",
                       want.kind, want.fm, want.found, want.addr, want.atype, want.rssi,
                       want.best_fm, want.count);
              $display("         got: kind %0d fm %b found %b addr %h type %0d rssi %0d bfm %b cnt %0d",
                       got.kind, got.fm, got.found, got.addr, got.atype, got.rssi,
                       got.best_fm, got.count);
            end
          end
        end
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        stall_left = gap_len(cycle_cnt[11:10] == 2'd2);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [BYTE_W-1:0] seq [$];
    int r;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_BYTE;
    req_if.payload_byte = '0;
    req_if.device_address = '0;
    req_if.address_type = '0;
    req_if.signal_strength = '0;
    req_if.connectable = 1'b0;
    rsp_if.ready = 1'b0;

    foreach (addr_pool[k]) addr_pool[k] = {16'($urandom), 32'($urandom)};

    // directed: empty pick, extremes, tracker element, zero length, short element
    add_op(REQ_PICK);
    add_commit({ADDR_W{1'b1}}, 2'd3, -8'sd128, 1'b1);
    seq = '{8'd4, MFR_TYPE, PFX_0, PFX_1, PFX_2};
    add_bytes(seq);
    add_commit('0, 2'd0, 8'sd127, 1'b0);
    add_op(REQ_PICK);
    seq = '{8'h00, 8'd4, MFR_TYPE, PFX_0, PFX_1, PFX_2};
    add_bytes(seq);
    add_commit(48'h0000_0000_0001, 2'd1, 8'sd0, 1'b0);
    seq = '{8'd3, MFR_TYPE, PFX_0, PFX_1};
    add_bytes(seq);
    add_commit(48'h8000_0000_0000, 2'd2, -8'sd1, 1'b0);
    add_op(REQ_CLEAR);
    add_op(REQ_PICK);

    while (req_backlog.size() < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 78) add_report();
      else if (r < 90) add_op(REQ_PICK);
      else if (r < 92) add_op(REQ_CLEAR);
      else add_op(req_e'($urandom_range(0, 3)));
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (req_backlog.size() != 0 || req_if.valid || answers_due.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_errors == 0 && answers_due.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/bact_pkg.sv
design/bact_if.sv
design/bact_parser.sv
design/bact_datapath.sv
design/bact_ctrl.sv
design/ble_adv_tracker_candidate_table.sv
tb/ble_adv_tracker_candidate_table_tb.sv
